// ===== hdl/vector_direction_color_map_assert.svh =====
// Assertion macros of the direction color mapper RTL.
// Included by the top level, which checks its own pipeline control.
`ifndef VECTOR_DIRECTION_COLOR_MAP_ASSERT_SVH
`define VECTOR_DIRECTION_COLOR_MAP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define VDCM_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define VDCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/vdcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and functions of the direction color mapper.
// No dependencies; imported by every module of the block.
package vdcm_pkg;

   localparam int COMPONENT_BITS_DEF = 16;
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int ANG_FRAC           = 16;
   localparam int GUARD              = 20;
   localparam int ANG_W              = 26;
   localparam int E_W                = 23;
   localparam int M_W                = 2 * E_W;
   localparam int S_W                = 51;
   localparam int H_W                = 19;
   localparam int P_W                = 2 * H_W;
   localparam int Q_SHIFT            = 28;

   // Angles in degrees with ANG_FRAC fraction bits.
   localparam logic [ANG_W-1:0] DEG90  = ANG_W'(90 * (1 << ANG_FRAC));
   localparam logic [ANG_W-1:0] DEG120 = ANG_W'(120 * (1 << ANG_FRAC));
   localparam logic [ANG_W-1:0] DEG180 = ANG_W'(180 * (1 << ANG_FRAC));
   localparam logic [ANG_W-1:0] DEG240 = ANG_W'(240 * (1 << ANG_FRAC));
   localparam logic [ANG_W-1:0] DEG360 = ANG_W'(360 * (1 << ANG_FRAC));

   // Ceiling bias for the division by 720 * 2^32, and the reciprocal of 720.
   localparam logic [S_W-1:0] CEIL_BIAS = 51'd3092376453119;
   localparam logic [H_W-1:0] RECIP_720 = 19'd372828;

   typedef struct packed {
      logic black;
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } trend_ctl_type;

   typedef struct packed {
      logic             black;
      logic [ANG_W-1:0] trend;
      logic             x_zero;
      logic             y_zero;
   } plunge_ctl_type;

   // CORDIC step angles atan(2^-i) in degrees, rounded to nearest.
   function automatic logic [ANG_W-1:0] atan_entry(input int idx);
      logic [ANG_W-1:0] v;
      unique case (idx)
         0:       v = ANG_W'(2949120);
         1:       v = ANG_W'(1740967);
         2:       v = ANG_W'(919879);
         3:       v = ANG_W'(466945);
         4:       v = ANG_W'(234379);
         5:       v = ANG_W'(117304);
         6:       v = ANG_W'(58666);
         7:       v = ANG_W'(29335);
         8:       v = ANG_W'(14668);
         9:       v = ANG_W'(7334);
         10:      v = ANG_W'(3667);
         11:      v = ANG_W'(1833);
         12:      v = ANG_W'(917);
         13:      v = ANG_W'(458);
         14:      v = ANG_W'(229);
         15:      v = ANG_W'(115);
         16:      v = ANG_W'(57);
         17:      v = ANG_W'(29);
         18:      v = ANG_W'(14);
         19:      v = ANG_W'(7);
         20:      v = ANG_W'(4);
         21:      v = ANG_W'(2);
         22:      v = ANG_W'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Final CORDIC angle: exact on the axes, otherwise clamped to [0,90].
   function automatic logic [ANG_W-1:0] ang_clamp(input logic signed [ANG_W-1:0] a,
                                                  input logic y_zero,
                                                  input logic x_zero);
      logic [ANG_W-1:0] v;
      priority if (y_zero)                  v = '0;
      else if (x_zero)                      v = DEG90;
      else if (a < 0)                       v = '0;
      else if (a > $signed(DEG90))          v = DEG90;
      else                                  v = a;
      return v;
   endfunction

endpackage

// ===== hdl/vector_direction_color_map.sv =====
`timescale 1ns / 1ps
// Top level of the direction color mapper: maps a 3D vector to an RGB color.
// Depends on vdcm_pkg, vdcm_cordic_stage, vdcm_blend and the assertion header.
//
// Usage:
//   The req_ channel takes one word per vector: x, y and z in req_tdata and the
//   good flag in req_tuser. The rsp_ channel returns one word per vector with
//   red, green and blue in rsp_tdata. csr_wen writes mask_enable from
//   csr_wdata; with it set, words flagged as bad come out black.
//   The datapath is a fully pipelined CORDIC: one word enters every cycle
//   while req_tready is high. Most of the pipeline depth comes from the two
//   CORDIC chains in series: azimuth together with the z gain pass, then the
//   plunge pass. Throughput is one word per cycle while rsp_tready stays high.
//   Reset clears all valid bits and mask_enable; no words are in flight after.
//   When the receiver stalls, the output register holds its word and a skid
//   register catches one more; the whole pipeline then freezes and req_tready
//   goes low until the skid word moves out. Nothing is lost or repeated.
module vector_direction_color_map import vdcm_pkg::*; #(
   parameter int COMPONENT_BITS = COMPONENT_BITS_DEF,
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF,
   localparam int IN_W          = ((3 * COMPONENT_BITS + 7) / 8) * 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [IN_W-1:0] req_tdata,   // vec_x, vec_y, vec_z
   input  logic            req_tuser,   // good_voxel
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [23:0]     rsp_tdata,   // red, green, blue
   input  logic            csr_wen,
   input  logic            csr_wdata
);

   `include "vector_direction_color_map_assert.svh"

   localparam int CB  = COMPONENT_BITS;
   localparam int N   = CORDIC_STEPS;
   localparam int DW  = CB + GUARD + 4;
   localparam int PAD = DW - CB - 1 - GUARD;
   localparam int TSW = $bits(trend_ctl_type);
   localparam int PSW = $bits(plunge_ctl_type);

   logic en;
   logic mask_ff;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 1'b0;
      end else if (csr_wen) begin
         mask_ff <= csr_wdata;
      end
   end

   // The pipeline moves only while the skid register is empty.
   logic skid_valid_ff;
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   // Input stage: flip downward vectors, take magnitudes, scale up.
   logic signed [CB:0]   sx, sy, sz, fx, fy, fz;
   logic [CB:0]          mag_x, mag_y;
   logic                 s0_valid_ff;
   trend_ctl_type        s0_ctl_ff;
   logic signed [DW-1:0] s0_x_ff, s0_y_ff, s0_z_ff;

   always_comb begin
      sx    = {req_tdata[CB-1], req_tdata[CB-1:0]};
      sy    = {req_tdata[2*CB-1], req_tdata[2*CB-1:CB]};
      sz    = {req_tdata[3*CB-1], req_tdata[3*CB-1:2*CB]};
      fx    = sz[CB] ? -sx : sx;
      fy    = sz[CB] ? -sy : sy;
      fz    = sz[CB] ? -sz : sz;
      mag_x = fx[CB] ? -fx : fx;
      mag_y = fy[CB] ? -fy : fy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ctl_ff.black  <= (mask_ff && !req_tuser) || (sx == 0 && sy == 0 && sz == 0);
         s0_ctl_ff.x_neg  <= fx[CB];
         s0_ctl_ff.y_neg  <= fy[CB];
         s0_ctl_ff.x_zero <= (mag_x == 0);
         s0_ctl_ff.y_zero <= (mag_y == 0);
         s0_x_ff          <= {{PAD{1'b0}}, mag_x, {GUARD{1'b0}}};
         s0_y_ff          <= {{PAD{1'b0}}, mag_y, {GUARD{1'b0}}};
         s0_z_ff          <= {{PAD{1'b0}}, fz, {GUARD{1'b0}}};
      end
   end

   // Azimuth CORDIC on (|x|,|y|) beside the gain pass on (z,0).
   logic signed [DW-1:0]    tx [0:N];
   logic signed [DW-1:0]    ty [0:N];
   logic signed [DW-1:0]    zx [0:N];
   logic signed [DW-1:0]    zy [0:N];
   logic signed [ANG_W-1:0] ta [0:N];
   logic                    tv [0:N];
   trend_ctl_type           tc [0:N];

   assign tx[0] = s0_x_ff;
   assign ty[0] = s0_y_ff;
   assign zx[0] = s0_z_ff;
   assign zy[0] = '0;
   assign ta[0] = '0;
   assign tv[0] = s0_valid_ff;
   assign tc[0] = s0_ctl_ff;

   genvar gi;
   generate
      for (gi = 0; gi < N; gi++) begin : g_trend
         vdcm_cordic_stage #(
            .DW(DW), .STEP(gi), .SW(TSW), .DUAL(1'b1)
         ) u_stage (
            .clock(clock), .reset(reset), .en(en),
            .valid_in(tv[gi]), .side_in(tc[gi]),
            .x_in(tx[gi]), .y_in(ty[gi]), .a_in(ta[gi]),
            .u_in(zx[gi]), .w_in(zy[gi]),
            .valid_out(tv[gi+1]), .side_out(tc[gi+1]),
            .x_out(tx[gi+1]), .y_out(ty[gi+1]), .a_out(ta[gi+1]),
            .u_out(zx[gi+1]), .w_out(zy[gi+1])
         );
      end
   endgenerate

   // Trend stage: clamp the angle, place it in its quadrant, wrap a full turn.
   logic [ANG_W-1:0]     t_ang, t_quad, t_trend;
   logic                 t_valid_ff;
   plunge_ctl_type       t_ctl_ff;
   logic signed [DW-1:0] t_x_ff, t_y_ff;

   always_comb begin
      t_ang = ang_clamp(ta[N], tc[N].y_zero, tc[N].x_zero);
      unique case ({tc[N].x_neg, tc[N].y_neg})
         2'b00:   t_quad = t_ang;
         2'b10:   t_quad = DEG180 - t_ang;
         2'b11:   t_quad = DEG180 + t_ang;
         default: t_quad = DEG360 - t_ang;
      endcase
      t_trend = (t_quad >= DEG360) ? t_quad - DEG360 : t_quad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff <= 1'b0;
      end else if (en) begin
         t_valid_ff <= tv[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ctl_ff.black  <= tc[N].black;
         t_ctl_ff.trend  <= t_trend;
         t_ctl_ff.x_zero <= (zx[N] == 0);
         t_ctl_ff.y_zero <= (tx[N] == 0);
         t_x_ff          <= zx[N];
         t_y_ff          <= tx[N];
      end
   end

   // Plunge CORDIC on (K*z, K*r).
   logic signed [DW-1:0]    px [0:N];
   logic signed [DW-1:0]    py [0:N];
   logic signed [ANG_W-1:0] pa [0:N];
   logic                    pv [0:N];
   plunge_ctl_type          pc [0:N];

   assign px[0] = t_x_ff;
   assign py[0] = t_y_ff;
   assign pa[0] = '0;
   assign pv[0] = t_valid_ff;
   assign pc[0] = t_ctl_ff;

   generate
      for (gi = 0; gi < N; gi++) begin : g_plunge
         vdcm_cordic_stage #(
            .DW(DW), .STEP(gi), .SW(PSW), .DUAL(1'b0)
         ) u_stage (
            .clock(clock), .reset(reset), .en(en),
            .valid_in(pv[gi]), .side_in(pc[gi]),
            .x_in(px[gi]), .y_in(py[gi]), .a_in(pa[gi]),
            .u_in('0), .w_in('0),
            .valid_out(pv[gi+1]), .side_out(pc[gi+1]),
            .x_out(px[gi+1]), .y_out(py[gi+1]), .a_out(pa[gi+1]),
            .u_out(), .w_out()
         );
      end
   endgenerate

   // Hue stage: per-channel weight D - c from the trend segment.
   logic [ANG_W-1:0] h_pl, h_tr, h_t1, h_t2;
   logic [E_W-1:0]   h_er, h_eg, h_eb;
   logic             c_valid_ff, c_black_ff;
   logic [E_W-1:0]   c_pl_ff, c_er_ff, c_eg_ff, c_eb_ff;

   always_comb begin
      h_pl = ang_clamp(pa[N], pc[N].y_zero, pc[N].x_zero);
      h_tr = pc[N].trend;
      h_t1 = h_tr - DEG120;
      h_t2 = h_tr - DEG240;
      priority if (h_tr <= DEG120) begin
         h_er = E_W'(h_tr);
         h_eg = E_W'(DEG120 - h_tr);
         h_eb = E_W'(DEG120);
      end else if (h_tr <= DEG240) begin
         h_er = E_W'(DEG120);
         h_eg = E_W'(h_t1);
         h_eb = E_W'(DEG120 - h_t1);
      end else begin
         h_er = E_W'(DEG120 - h_t2);
         h_eg = E_W'(DEG120);
         h_eb = E_W'(h_t2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= pv[N];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_black_ff <= pc[N].black;
         c_pl_ff    <= E_W'(h_pl);
         c_er_ff    <= h_er;
         c_eg_ff    <= h_eg;
         c_eb_ff    <= h_eb;
      end
   end

   // Blend units, with valid and black carried alongside their three stages.
   logic [7:0] red, green, blue;
   logic [2:0] b_valid_ff, b_black_ff;

   vdcm_blend u_blend_r (.clock(clock), .en(en), .weight(c_er_ff), .plunge(c_pl_ff),
                         .color(red));
   vdcm_blend u_blend_g (.clock(clock), .en(en), .weight(c_eg_ff), .plunge(c_pl_ff),
                         .color(green));
   vdcm_blend u_blend_b (.clock(clock), .en(en), .weight(c_eb_ff), .plunge(c_pl_ff),
                         .color(blue));

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= '0;
      end else if (en) begin
         b_valid_ff <= {b_valid_ff[1:0], c_valid_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_black_ff <= {b_black_ff[1:0], c_black_ff};
      end
   end

   logic        fin_valid;
   logic [23:0] fin_data;
   assign fin_valid = b_valid_ff[2];
   assign fin_data  = b_black_ff[2] ? 24'd0 : {blue, green, red};

   // Output register with one skid word behind it.
   logic        rsp_valid_ff;
   logic [23:0] rsp_data_ff, skid_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_tready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff <= fin_valid;
      end else if (fin_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_data_ff <= fin_data;
      end else begin
         skid_data_ff <= fin_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A skid word only ever sits behind a held output word.
   `VDCM_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff, "skid word without output word")
   // A stalled skid word stays put.
   `VDCM_ASSERT_NEXT(a_skid_hold, clock, reset, skid_valid_ff && !rsp_tready, skid_valid_ff, "skid word dropped during stall")
   // An untaken output word is never withdrawn.
   `VDCM_ASSERT_NEXT(a_out_hold, clock, reset, rsp_valid_ff && !rsp_tready, rsp_valid_ff, "output word dropped during stall")

endmodule

// ===== hdl/vdcm_cordic_stage.sv =====
`timescale 1ns / 1ps
// One registered vectoring CORDIC step, with an optional second rotation lane.
// Depends on vdcm_pkg for the step angle table.
module vdcm_cordic_stage import vdcm_pkg::*; #(
   parameter int DW   = 40,
   parameter int STEP = 0,
   parameter int SW   = 1,
   parameter bit DUAL = 1'b0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    valid_in,
   input  logic [SW-1:0]           side_in,
   input  logic signed [DW-1:0]    x_in,
   input  logic signed [DW-1:0]    y_in,
   input  logic signed [ANG_W-1:0] a_in,
   input  logic signed [DW-1:0]    u_in,
   input  logic signed [DW-1:0]    w_in,
   output logic                    valid_out,
   output logic [SW-1:0]           side_out,
   output logic signed [DW-1:0]    x_out,
   output logic signed [DW-1:0]    y_out,
   output logic signed [ANG_W-1:0] a_out,
   output logic signed [DW-1:0]    u_out,
   output logic signed [DW-1:0]    w_out
);

   localparam logic signed [ANG_W-1:0] STEP_ANG = $signed(atan_entry(STEP));

   logic                    valid_ff;
   logic [SW-1:0]           side_ff;
   logic signed [DW-1:0]    x_ff, y_ff, x_in_nx, y_in_nx;
   logic signed [ANG_W-1:0] a_ff, a_in_nx;

   // Rotate toward the x axis; the sign of y picks the direction.
   always_comb begin
      if (y_in >= 0) begin
         x_in_nx = x_in + (y_in >>> STEP);
         y_in_nx = y_in - (x_in >>> STEP);
         a_in_nx = a_in + STEP_ANG;
      end else begin
         x_in_nx = x_in - (y_in >>> STEP);
         y_in_nx = y_in + (x_in >>> STEP);
         a_in_nx = a_in - STEP_ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         x_ff    <= x_in_nx;
         y_ff    <= y_in_nx;
         a_ff    <= a_in_nx;
      end
   end

   assign valid_out = valid_ff;
   assign side_out  = side_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign a_out     = a_ff;

   // The second lane only tracks the magnitude, so it keeps no angle.
   generate
      if (DUAL) begin : g_dual
         logic signed [DW-1:0] u_ff, w_ff, u_in_nx, w_in_nx;

         always_comb begin
            if (w_in >= 0) begin
               u_in_nx = u_in + (w_in >>> STEP);
               w_in_nx = w_in - (u_in >>> STEP);
            end else begin
               u_in_nx = u_in - (w_in >>> STEP);
               w_in_nx = w_in + (u_in >>> STEP);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               u_ff <= u_in_nx;
               w_ff <= w_in_nx;
            end
         end

         assign u_out = u_ff;
         assign w_out = w_ff;
      end else begin : g_single
         assign u_out = '0;
         assign w_out = '0;
      end
   endgenerate

endmodule

// ===== hdl/vdcm_blend.sv =====
`timescale 1ns / 1ps
// Three-stage blend of one color channel toward white by the plunge angle.
// Depends on vdcm_pkg for the fixed-point constants.
module vdcm_blend import vdcm_pkg::*; (
   input  logic           clock,
   input  logic           en,
   input  logic [E_W-1:0] weight,
   input  logic [E_W-1:0] plunge,
   output logic [7:0]     color
);

   logic [M_W-1:0] prod_ff;
   logic [H_W-1:0] quot_ff;
   logic [P_W-1:0] recip_ff;
   logic [S_W-1:0] scaled;

   // 17 * prod plus the ceiling bias; 255 / 10800 reduces to 17 / 720.
   assign scaled = (S_W'(prod_ff) << 4) + S_W'(prod_ff) + CEIL_BIAS;

   // Product, shift by 2^32, then divide by 720 through its reciprocal.
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= M_W'(weight) * M_W'(plunge);
         quot_ff  <= scaled[32 +: H_W];
         recip_ff <= P_W'(quot_ff) * P_W'(RECIP_720);
      end
   end

   // The channel is 255 minus the ceiling of the blend loss.
   assign color = 8'd255 - recip_ff[Q_SHIFT +: 8];

endmodule
